FILE: rtl/core/nearest_ray_segment_hit_macros.svh
// Assertion macros for the ray caster
`ifndef NEAREST_RAY_SEGMENT_HIT_MACROS_SVH
`define NEAREST_RAY_SEGMENT_HIT_MACROS_SVH
`ifndef SYNTH
`define NRSH_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define NRSH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NRSH_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define NRSH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/nrsh_pkg.sv
package nrsh_pkg;

   localparam int COORD_W    = 24;
   localparam int DIR_W      = 16;
   localparam int DIST_W     = 23;
   localparam int SEGIDX_W   = 6;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DEN_W      = 42;
   localparam int NUM_W      = 51;
   localparam int QUOT_W     = DIST_W;
   localparam int FRAC_SHIFT = 14;
   localparam int PRE_SHIFT  = QUOT_W - FRAC_SHIFT;
   localparam int ENTRY_W    = 4 * COORD_W;
   localparam int DEFAULT_MAX_SEGMENTS = 64;

   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 23'd2560000;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_CAST  = 2'd2;

   localparam logic [1:0] CSR_LIGHT_X      = 2'd0;
   localparam logic [1:0] CSR_LIGHT_Y      = 2'd1;
   localparam logic [1:0] CSR_MAX_DISTANCE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_POINT,
      ST_FINISH
   } state_type;

   // one slot of the divider chain
   typedef struct packed {
      logic              sat;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  rem;
      logic [QUOT_W-1:0] qn;
   } divcell_type;

endpackage

FILE: rtl/core/nrsh_div_cell.sv
module nrsh_div_cell #(
   parameter int IDX_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  nrsh_pkg::divcell_type cell_in,
   input  logic [IDX_W-1:0]      idx_in,
   output logic                  valid_out,
   output nrsh_pkg::divcell_type cell_out,
   output logic [IDX_W-1:0]      idx_out
);
   import nrsh_pkg::*;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;
   divcell_type      data_in;
   divcell_type      data_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;

   // one restoring step: next numerator bit comes off the top of qn
   always_comb begin
      shifted      = {cell_in.rem, cell_in.qn[QUOT_W-1]};
      ge           = (shifted >= {1'b0, cell_in.den});
      diff         = shifted - {1'b0, cell_in.den};
      data_in      = cell_in;
      data_in.rem  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      data_in.qn   = {cell_in.qn[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      idx_ff  <= idx_in;
   end

   assign valid_out = valid_ff;
   assign cell_out  = data_ff;
   assign idx_out   = idx_ff;

endmodule

FILE: rtl/core/nearest_ray_segment_hit.sv
// channel  direction  handshake               payload
// req      in         req_valid / req_ready   mode, segment end points, ray direction
// rsp      out        rsp_valid / rsp_ready   hit, point, distance, segment index
// csr      in         csr_we                  csr_index, csr_wdata
//
// Clear and load keep the block in idle. In a cast the table is read one segment a cycle
// into a 4-stage intersection pipe and a 23-cell divider chain, then the chain drains and
// the hit point is formed. Reset is synchronous and clears the segment count; the table
// itself is not cleared. A result waiting in the output register holds the block only at
// the end of the next cast.
`include "nearest_ray_segment_hit_macros.svh"

module nearest_ray_segment_hit #(
   parameter int MAX_SEGMENTS = nrsh_pkg::DEFAULT_MAX_SEGMENTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [nrsh_pkg::COORD_W-1:0]  req_seg_start_x,
   input  logic signed [nrsh_pkg::COORD_W-1:0]  req_seg_start_y,
   input  logic signed [nrsh_pkg::COORD_W-1:0]  req_seg_end_x,
   input  logic signed [nrsh_pkg::COORD_W-1:0]  req_seg_end_y,
   input  logic signed [nrsh_pkg::DIR_W-1:0]    req_dir_x,
   input  logic signed [nrsh_pkg::DIR_W-1:0]    req_dir_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic signed [nrsh_pkg::COORD_W-1:0]  rsp_hit_x,
   output logic signed [nrsh_pkg::COORD_W-1:0]  rsp_hit_y,
   output logic [nrsh_pkg::DIST_W-1:0]          rsp_hit_distance,
   output logic [nrsh_pkg::SEGIDX_W-1:0]        rsp_hit_segment,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [nrsh_pkg::COORD_W-1:0]         csr_wdata
);
   import nrsh_pkg::*;

   localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int IW  = (AW > SEGIDX_W) ? AW : SEGIDX_W;
   localparam int LAT = QUOT_W + 8;
   localparam int DW  = $clog2(LAT + 1);
   localparam int PW  = DIR_W + DIST_W + 1;

   // control
   state_type state_ff, state_in;
   logic req_xfer, cast_start, issue, load_rsp;
   logic [CW-1:0] count_ff, sweep_ff;
   logic [DW-1:0] drain_ff;

   // configuration and ray
   logic signed [COORD_W-1:0] light_x_ff, light_y_ff;
   logic [DIST_W-1:0]         maxd_ff;
   logic signed [DIR_W-1:0]   dx_ff, dy_ff;

   // table
   logic [ENTRY_W-1:0] seg_mem [MAX_SEGMENTS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic [AW-1:0]      rd_idx_ff;

   // intersection pipe
   logic signed [COORD_W-1:0] ax, ay, bx, by;
   logic                      s1_valid_ff;
   logic [AW-1:0]             s1_idx_ff;
   logic signed [DIFF_W-1:0]  ex_ff, ey_ff, wx_ff, wy_ff;
   logic                      s2_valid_ff;
   logic [AW-1:0]             s2_idx_ff;
   logic signed [DIR_W+DIFF_W-1:0] p_dxey_ff, p_dyex_ff, p_wxdy_ff, p_wydx_ff;
   logic signed [2*DIFF_W-1:0]     p_wxey_ff, p_wyex_ff;
   logic                      s3_valid_ff;
   logic [AW-1:0]             s3_idx_ff;
   logic signed [DEN_W-1:0]   den_ff, n2_ff;
   logic signed [NUM_W-1:0]   n1_ff;
   logic signed [DEN_W-1:0]   dn, n2a;
   logic signed [NUM_W-1:0]   n1a;
   logic [DEN_W-1:0]          n1_hi;
   logic                      accept;
   divcell_type               cin;

   // divider chain
   logic        chain_valid [QUOT_W+1];
   divcell_type chain_data  [QUOT_W+1];
   logic [AW-1:0] chain_idx [QUOT_W+1];
   logic          pipe_busy;

   // best hit
   logic [DIST_W-1:0] t_fin;
   logic [DIST_W-1:0] best_ff;
   logic [AW-1:0]     best_idx_ff;
   logic              found_ff;

   // hit point
   logic signed [PW-1:0]      px_ff, py_ff, adj_x, adj_y;
   logic signed [PW-FRAC_SHIFT-1:0] qx, qy;
   logic signed [COORD_W+2:0] sum_x, sum_y;
   logic signed [COORD_W-1:0] hx, hy;
   logic [IW-1:0]             idx_ext;

   // output register
   logic                      rsp_valid_ff, rsp_hit_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic [SEGIDX_W-1:0]       rsp_seg_ff;

   assign req_xfer = req_valid && req_ready;

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_mode == MODE_CAST) begin
               state_in = (count_ff == '0) ? ST_DRAIN : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_ff + CW'(1) == count_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_ff == DW'(LAT - 1)) state_in = ST_POINT;
         end
         ST_POINT:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      issue      = (state_ff == ST_SWEEP);
      load_rsp   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      cast_start = req_xfer && req_mode == MODE_CAST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sweep_ff <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_xfer && req_mode == MODE_CLEAR) begin
            count_ff <= '0;
         end else if (req_xfer && req_mode == MODE_LOAD && count_ff < CW'(MAX_SEGMENTS)) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cast_start) sweep_ff <= '0;
         else if (issue) sweep_ff <= sweep_ff + CW'(1);
         if (state_ff == ST_DRAIN) drain_ff <= drain_ff + DW'(1);
         else drain_ff <= '0;
      end
   end

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         maxd_ff    <= MAX_DISTANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X:      light_x_ff <= $signed(csr_wdata);
            CSR_LIGHT_Y:      light_y_ff <= $signed(csr_wdata);
            CSR_MAX_DISTANCE: maxd_ff    <= csr_wdata[DIST_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cast_start) begin
         dx_ff <= req_dir_x;
         dy_ff <= req_dir_y;
      end
   end

   // ---------------------------------------------------------------- table
   always_ff @(posedge clock) begin
      if (req_xfer && req_mode == MODE_LOAD && count_ff < CW'(MAX_SEGMENTS)) begin
         seg_mem[count_ff[AW-1:0]] <= {req_seg_start_x, req_seg_start_y,
                                        req_seg_end_x, req_seg_end_y};
      end
      rd_data_ff <= seg_mem[sweep_ff[AW-1:0]];
      rd_idx_ff  <= sweep_ff[AW-1:0];
   end

   // ---------------------------------------------------------------- intersection
   always_comb begin
      ax = $signed(rd_data_ff[4*COORD_W-1:3*COORD_W]);
      ay = $signed(rd_data_ff[3*COORD_W-1:2*COORD_W]);
      bx = $signed(rd_data_ff[2*COORD_W-1:COORD_W]);
      by = $signed(rd_data_ff[COORD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      ex_ff     <= DIFF_W'(bx) - DIFF_W'(ax);
      ey_ff     <= DIFF_W'(by) - DIFF_W'(ay);
      wx_ff     <= DIFF_W'(ax) - DIFF_W'(light_x_ff);
      wy_ff     <= DIFF_W'(ay) - DIFF_W'(light_y_ff);
      s1_idx_ff <= rd_idx_ff;
      p_dxey_ff <= dx_ff * ey_ff;
      p_dyex_ff <= dy_ff * ex_ff;
      p_wxdy_ff <= wx_ff * dy_ff;
      p_wydx_ff <= wy_ff * dx_ff;
      p_wxey_ff <= wx_ff * ey_ff;
      p_wyex_ff <= wy_ff * ex_ff;
      s2_idx_ff <= s1_idx_ff;
      den_ff    <= DEN_W'(p_dxey_ff) - DEN_W'(p_dyex_ff);
      n1_ff     <= NUM_W'(p_wxey_ff) - NUM_W'(p_wyex_ff);
      n2_ff     <= DEN_W'(p_wxdy_ff) - DEN_W'(p_wydx_ff);
      s3_idx_ff <= s2_idx_ff;
   end

   // sign-normalise so the denominator is positive, then test the fractions
   always_comb begin
      dn     = den_ff[DEN_W-1] ? -den_ff : den_ff;
      n1a    = den_ff[DEN_W-1] ? -n1_ff  : n1_ff;
      n2a    = den_ff[DEN_W-1] ? -n2_ff  : n2_ff;
      n1_hi  = n1a[NUM_W-1:PRE_SHIFT];
      accept = (den_ff != '0) && !n1a[NUM_W-1] && !n2a[DEN_W-1] && (n2a <= dn);
      cin.sat = (n1_hi >= $unsigned(dn));
      cin.den = $unsigned(dn);
      cin.rem = n1_hi;
      cin.qn  = {n1a[PRE_SHIFT-1:0], {(QUOT_W - PRE_SHIFT){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         chain_valid[0] <= 1'b0;
      end else begin
         rd_valid_ff    <= issue;
         s1_valid_ff    <= rd_valid_ff;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         chain_valid[0] <= s3_valid_ff && accept;
      end
   end

   always_ff @(posedge clock) begin
      chain_data[0] <= cin;
      chain_idx[0]  <= s3_idx_ff;
   end

   // ---------------------------------------------------------------- divider chain
   for (genvar g = 0; g < QUOT_W; g++) begin : g_div
      nrsh_div_cell #(.IDX_W(AW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[g]),
         .cell_in   (chain_data[g]),
         .idx_in    (chain_idx[g]),
         .valid_out (chain_valid[g+1]),
         .cell_out  (chain_data[g+1]),
         .idx_out   (chain_idx[g+1])
      );
   end

   always_comb begin
      pipe_busy = rd_valid_ff || s1_valid_ff || s2_valid_ff || s3_valid_ff;
      for (int k = 0; k <= QUOT_W; k++) begin
         pipe_busy = pipe_busy || chain_valid[k];
      end
   end

   // ---------------------------------------------------------------- nearest
   assign t_fin = chain_data[QUOT_W].sat ? '1 : chain_data[QUOT_W].qn;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cast_start) begin
         found_ff <= 1'b0;
      end else if (chain_valid[QUOT_W] && t_fin < best_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cast_start) begin
         best_ff     <= maxd_ff;
         best_idx_ff <= '0;
      end else if (chain_valid[QUOT_W] && t_fin < best_ff) begin
         best_ff     <= t_fin;
         best_idx_ff <= chain_idx[QUOT_W];
      end
   end

   // ---------------------------------------------------------------- hit point
   always_ff @(posedge clock) begin
      if (state_ff == ST_POINT) begin
         px_ff <= dx_ff * $signed({1'b0, best_ff});
         py_ff <= dy_ff * $signed({1'b0, best_ff});
      end
   end

   // truncate toward zero: bias negative products before the shift
   always_comb begin
      adj_x = px_ff + (px_ff[PW-1] ? PW'((1 << FRAC_SHIFT) - 1) : PW'(0));
      adj_y = py_ff + (py_ff[PW-1] ? PW'((1 << FRAC_SHIFT) - 1) : PW'(0));
      qx    = adj_x[PW-1:FRAC_SHIFT];
      qy    = adj_y[PW-1:FRAC_SHIFT];
      sum_x = (COORD_W+3)'(light_x_ff) + (COORD_W+3)'(qx);
      sum_y = (COORD_W+3)'(light_y_ff) + (COORD_W+3)'(qy);
      if (sum_x > (COORD_W+3)'(8388607))       hx = {1'b0, {(COORD_W-1){1'b1}}};
      else if (sum_x < -(COORD_W+3)'(8388608)) hx = {1'b1, {(COORD_W-1){1'b0}}};
      else                                      hx = sum_x[COORD_W-1:0];
      if (sum_y > (COORD_W+3)'(8388607))       hy = {1'b0, {(COORD_W-1){1'b1}}};
      else if (sum_y < -(COORD_W+3)'(8388608)) hy = {1'b1, {(COORD_W-1){1'b0}}};
      else                                      hy = sum_y[COORD_W-1:0];
      idx_ext = IW'(best_idx_ff);
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hit_ff  <= found_ff;
         rsp_x_ff    <= found_ff ? hx : '0;
         rsp_y_ff    <= found_ff ? hy : '0;
         rsp_dist_ff <= found_ff ? best_ff : '0;
         rsp_seg_ff  <= found_ff ? idx_ext[SEGIDX_W-1:0] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_x        = rsp_x_ff;
   assign rsp_hit_y        = rsp_y_ff;
   assign rsp_hit_distance = rsp_dist_ff;
   assign rsp_hit_segment  = rsp_seg_ff;

   // ---------------------------------------------------------------- checks
   `NRSH_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_SEGMENTS), "segment count over capacity")
   `NRSH_ASSERT_ALWAYS(a_idle_empty, clock, reset, !(state_ff == ST_IDLE) || !pipe_busy, "idle with segments in flight")
   `NRSH_ASSERT_NEXT(a_result_out, clock, reset, load_rsp, rsp_valid_ff, "result transfer not presented")

endmodule
